/* rtl/mss_pkg.sv */
// Shared types, codes and the digit decode table for the seven-segment scanner.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mss_pkg;

    // Operation codes carried by the item channel
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIGIT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BLINK_FIRST  = 2'd1;
    localparam logic [1:0] CFG_BLINK_LAST   = 2'd2;
    localparam logic [1:0] CFG_BLINK_PERIOD = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned POS_W      = 3;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] DOT_MASK  = 8'h80;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] first_digit;
        logic [POS_W-1:0] last_digit;
        logic [3:0]       bcd_value;
        logic             clear_first;
    } t_item;

    typedef struct packed {
        logic             wr;
        logic             clear;
        logic             toggle;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] last;
        logic [SEG_W-1:0] pattern;
    } t_store_cmd;

    // a is bit 0 through g is bit 6; codes above nine show blank
    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] bcd);
        logic [SEG_W-1:0] seg;
        case (bcd)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

/* rtl/mss_if.sv */
// Valid/ready channel interfaces for the scanner: item input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface mss_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [2:0] first_digit;
    logic [2:0] last_digit;
    logic [3:0] bcd_value;
    logic       clear_first;

    modport source (output valid, op, first_digit, last_digit, bcd_value, clear_first,
                    input ready);
    modport sink   (input valid, op, first_digit, last_digit, bcd_value, clear_first,
                    output ready);
endinterface

interface mss_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [2:0] digit_select;

    modport source (output valid, segments, digit_select, input ready);
    modport sink   (input valid, segments, digit_select, output ready);
endinterface

/* rtl/mux_seven_segment_scanner_top.sv */
// Multiplexed seven-segment scanner top: input register, pattern store, scan sequencer,
// configuration registers and the result register. Depends on mss_pkg, mss_if and submodules.
// A refresh tick passes through the input register and then the result register.
// Throughput: one item per cycle; only a stalled result register holds the input stage.
// Reset (synchronous, active low): store blank, digit count 4 (MAX_DIGITS if fewer), blink off,
// counter zero, active digit set to the last digit in use.
`timescale 1ns / 1ps

module mux_seven_segment_scanner_top
    import mss_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 8
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mss_item_if.sink              i_item,
    mss_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Index wide enough for the store, count wide enough to hold MAX_DIGITS itself
    localparam int unsigned IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int unsigned CNT_RST = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;
    localparam int unsigned CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [4:0]  MAX_D5  = 5'(MAX_DIGITS);

    // Clamp a raw digit count into 1..MAX_DIGITS
    function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] raw);
        logic [CNT_W-1:0] cnt;
        if (raw == 4'd0) begin
            cnt = CNT_W'(1);
        end else if ({1'b0, raw} > MAX_D5) begin
            cnt = CNT_W'(MAX_DIGITS);
        end else begin
            cnt = CNT_W'(raw);
        end
        return cnt;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers; the digit count is held already clamped
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]      r_count;
    logic [POS_W-1:0]      r_blink_first;
    logic [POS_W-1:0]      r_blink_last;
    logic [CFG_DATA_W-1:0] r_blink_period;
    logic [CNT_W-1:0]      w_new_count;
    logic                  w_count_we;
    logic                  w_blink_we;

    assign w_new_count = clamp_count(i_cfg_data[3:0]);
    assign w_count_we  = i_cfg_we && (i_cfg_idx == CFG_DIGIT_COUNT);
    assign w_blink_we  = i_cfg_we && ((i_cfg_idx == CFG_BLINK_FIRST)
                                   || (i_cfg_idx == CFG_BLINK_LAST)
                                   || (i_cfg_idx == CFG_BLINK_PERIOD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= CNT_W'(CNT_RST);
            r_blink_first  <= '0;
            r_blink_last   <= '0;
            r_blink_period <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIGIT_COUNT:  r_count        <= w_new_count;
                CFG_BLINK_FIRST:  r_blink_first  <= i_cfg_data[POS_W-1:0];
                CFG_BLINK_LAST:   r_blink_last   <= i_cfg_data[POS_W-1:0];
                CFG_BLINK_PERIOD: r_blink_period <= i_cfg_data;
                default:          r_count        <= r_count;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input stage: the held item moves on unless it is a tick facing a full
    // result register
    // ---------------------------------------------------------------
    logic             r_out_valid;
    logic [SEG_W-1:0] r_out_seg;
    logic [POS_W-1:0] r_out_sel;
    logic             w_s1_valid;
    t_item            w_s1_item;
    logic             w_out_free;
    logic             w_is_tick;
    logic             w_advance;
    logic             w_tick_fire;

    assign w_out_free  = !r_out_valid || o_result.ready;
    assign w_is_tick   = (w_s1_item.op == OP_TICK);
    assign w_advance   = w_s1_valid && (!w_is_tick || w_out_free);
    assign w_tick_fire = w_advance && w_is_tick;

    mss_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    // ---------------------------------------------------------------
    // Pattern store: write only positions inside the digit count in use
    // ---------------------------------------------------------------
    t_store_cmd       w_cmd;
    logic [SEG_W-1:0] w_rd_data;
    logic [IDX_W-1:0] w_next_idx;
    logic [IDX_W-1:0] w_active_idx;
    logic             w_blank;
    logic             w_is_write;

    assign w_is_write    = w_advance && (w_s1_item.op == OP_WRITE);
    assign w_cmd.clear   = w_is_write && w_s1_item.clear_first;
    assign w_cmd.wr      = w_is_write && (CMP_W'(w_s1_item.first_digit) < CMP_W'(r_count));
    assign w_cmd.toggle  = w_advance && (w_s1_item.op == OP_TOGGLE);
    assign w_cmd.pos     = w_s1_item.first_digit;
    assign w_cmd.last    = w_s1_item.last_digit;
    assign w_cmd.pattern = seg_decode(w_s1_item.bcd_value);

    mss_store #(
        .MAX_DIGITS (MAX_DIGITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_idx  (w_next_idx),
        .o_rd_data (w_rd_data)
    );

    mss_scan #(
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .CNT_RST (CNT_RST)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (w_tick_fire),
        .i_count_we     (w_count_we),
        .i_blink_we     (w_blink_we),
        .i_new_count    (w_new_count),
        .i_count        (r_count),
        .i_blink_first  (r_blink_first),
        .i_blink_last   (r_blink_last),
        .i_blink_period (r_blink_period),
        .o_active_idx   (w_active_idx),
        .o_next_idx     (w_next_idx),
        .o_blank        (w_blank)
    );

    // ---------------------------------------------------------------
    // Result register: load on a tick, drop once the transaction is taken
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_fire) begin
            r_out_seg <= w_blank ? SEG_BLANK : w_rd_data;
            r_out_sel <= POS_W'(w_next_idx);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.segments     = r_out_seg;
    assign o_result.digit_select = r_out_sel;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(w_active_idx) < r_count)
        else $error("active digit beyond digit count");

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_tick_fire))
        else $error("result appeared without a refresh tick");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (w_s1_valid && w_is_tick && r_out_valid))
        else $error("input stalled without a blocked tick");

endmodule

/* rtl/mss_in_reg.sv */
// Input register stage: captures one item transaction and holds it until consumed.
// Depends on mss_pkg and mss_item_if.
`timescale 1ns / 1ps

module mss_in_reg
    import mss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mss_item_if.sink    i_item,
    input  logic        i_advance,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    assign i_item.ready = !r_valid || i_advance;
    assign w_take       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.op          <= i_item.op;
            r_item.first_digit <= i_item.first_digit;
            r_item.last_digit  <= i_item.last_digit;
            r_item.bcd_value   <= i_item.bcd_value;
            r_item.clear_first <= i_item.clear_first;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/mss_store.sv */
// Segment pattern store: one register per digit with clear, write and dot toggle.
// Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_store
    import mss_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 8,
    parameter int unsigned IDX_W      = 3
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_cmd       i_cmd,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [SEG_W-1:0] o_rd_data
);

    localparam int unsigned CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [SEG_W-1:0] r_store [MAX_DIGITS];
    logic [SEG_W-1:0] n_store [MAX_DIGITS];

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            n_store[i] = i_cmd.clear ? SEG_BLANK : r_store[i];
            if (i_cmd.wr && (CMP_W'(i) == CMP_W'(i_cmd.pos))) begin
                n_store[i] = i_cmd.pattern;
            end
            // entries past the store cannot be named, so the range clamps itself
            if (i_cmd.toggle && (CMP_W'(i) >= CMP_W'(i_cmd.pos))
                             && (CMP_W'(i) <= CMP_W'(i_cmd.last))) begin
                n_store[i] = r_store[i] ^ DOT_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (!i_rst_n) begin
                r_store[i] <= SEG_BLANK;
            end else begin
                r_store[i] <= n_store[i];
            end
        end
    end

    assign o_rd_data = r_store[i_rd_idx];

endmodule

/* rtl/mss_scan.sv */
// Scan sequencer: active digit index, blink counter and blanking decision.
// Depends on mss_pkg.
`timescale 1ns / 1ps

module mss_scan
    import mss_pkg::*;
#(
    parameter int unsigned IDX_W   = 3,
    parameter int unsigned CNT_W   = 4,
    parameter int unsigned CNT_RST = 4
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic                  i_count_we,
    input  logic                  i_blink_we,
    input  logic [CNT_W-1:0]      i_new_count,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [POS_W-1:0]      i_blink_first,
    input  logic [POS_W-1:0]      i_blink_last,
    input  logic [CFG_DATA_W-1:0] i_blink_period,
    output logic [IDX_W-1:0]      o_active_idx,
    output logic [IDX_W-1:0]      o_next_idx,
    output logic                  o_blank
);

    localparam int unsigned CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    logic [IDX_W-1:0]      r_idx;
    logic [CFG_DATA_W-1:0] r_blink_cnt;
    logic [IDX_W-1:0]      n_idx;
    logic [CFG_DATA_W-1:0] n_blink_cnt;
    logic [CNT_W-1:0]      w_idx_inc;
    logic [CFG_DATA_W-1:0] w_cnt_inc;
    logic                  w_wrap;

    assign w_idx_inc = CNT_W'(r_idx) + CNT_W'(1);
    assign n_idx     = (w_idx_inc == i_count) ? '0 : IDX_W'(w_idx_inc);
    assign w_wrap    = (n_idx == '0);
    assign w_cnt_inc = r_blink_cnt + CFG_DATA_W'(1);

    always_comb begin
        n_blink_cnt = r_blink_cnt;
        if (w_wrap) begin
            n_blink_cnt = (w_cnt_inc >= i_blink_period) ? '0 : w_cnt_inc;
        end
    end

    assign o_blank = (i_blink_period != '0)
                  && (n_blink_cnt >= (i_blink_period >> 1))
                  && (CMP_W'(n_idx) >= CMP_W'(i_blink_first))
                  && (CMP_W'(n_idx) <= CMP_W'(i_blink_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_W'(CNT_RST - 1);
            r_blink_cnt <= '0;
        end else begin
            if (i_count_we) begin
                r_idx <= IDX_W'(i_new_count - CNT_W'(1));
            end else if (i_tick) begin
                r_idx <= n_idx;
            end
            if (i_blink_we) begin
                r_blink_cnt <= '0;
            end else if (i_tick) begin
                r_blink_cnt <= n_blink_cnt;
            end
        end
    end

    assign o_active_idx = r_idx;
    assign o_next_idx   = n_idx;

endmodule
